// File: rtl/core/albs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package albs_pkg;

  localparam int unsigned LEN_W       = 8;
  localparam int unsigned POS_W       = 9;
  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned WORD_BYTES  = 8;
  localparam int unsigned NUM_STATS   = 7;
  localparam int unsigned STAT_W      = 32;
  localparam int unsigned TIMER_W     = 24;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 24'd1000;
  localparam logic [7:0]         NEWLINE_CHAR  = 8'd10;

  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic [2:0] REQ_DATA = 3'd0;
  localparam logic [2:0] REQ_EOF  = 3'd1;
  localparam logic [2:0] REQ_ACK  = 3'd2;
  localparam logic [2:0] REQ_TICK = 3'd3;
  localparam logic [2:0] REQ_STAT = 3'd4;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_BUSY     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_STALE    = 3'd3;
  localparam logic [2:0] ST_ACK_OK   = 3'd4;
  localparam logic [2:0] ST_LOST     = 3'd5;
  localparam logic [2:0] ST_SENT     = 3'd6;
  localparam logic [2:0] ST_STAT     = 3'd7;

  localparam int unsigned STAT_ORIG       = 0;
  localparam int unsigned STAT_ORIG_BYTES = 1;
  localparam int unsigned STAT_TOTAL      = 2;
  localparam int unsigned STAT_DROPS      = 3;
  localparam int unsigned STAT_SENT       = 4;
  localparam int unsigned STAT_ACKS       = 5;
  localparam int unsigned STAT_TIMEOUTS   = 6;

  typedef struct packed {
    logic              is_frame;
    logic [2:0]        status;
    logic [STAT_W-1:0] stat_value;
    logic              seq_out;
    logic              hdr_seq;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic              is_frame;
    logic [63:0]       frame_word;
    logic [3:0]        word_bytes;
    logic              last_word;
    logic              seq_bit;
    logic [2:0]        status;
    logic [STAT_W-1:0] stat_value;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/albs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module albs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 11,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/albs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module albs_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire albs_pkg::cmd_t push_cmd_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output albs_pkg::cmd_t    head_o
);

  albs_pkg::cmd_t                   mem_q [albs_pkg::QUEUE_DEPTH];
  logic [albs_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [albs_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [albs_pkg::QCNT_W-1:0]      count_q, count_d;

  function automatic logic [albs_pkg::QPTR_W-1:0] next_ptr(
    input logic [albs_pkg::QPTR_W-1:0] ptr
  );
    if (ptr == albs_pkg::QPTR_W'(albs_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + albs_pkg::QPTR_W'(1);
  endfunction

  assign full_o  = (count_q == albs_pkg::QCNT_W'(albs_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + albs_pkg::QCNT_W'(push_i) - albs_pkg::QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/albs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module albs_front #(
  parameter int unsigned MAX_PAYLOAD = 80,
  parameter int unsigned WORDS       = (MAX_PAYLOAD + albs_pkg::HDR_BYTES + 7) / 8,
  parameter int unsigned AW          = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_valid_i,
  output logic                              s_ready_o,
  input  wire logic [2:0]                   req_type_i,
  input  wire logic [7:0]                   data_byte_i,
  input  wire logic [15:0]                  ack_number_i,
  input  wire logic                         drop_frame_i,
  input  wire logic [2:0]                   stat_select_i,
  input  wire logic [albs_pkg::TIMER_W-1:0] timeout_i,
  input  wire logic                         q_full_i,
  input  wire logic                         frame_done_i,
  output logic                              push_o,
  output albs_pkg::cmd_t                    cmd_o,
  output logic [7:0]                        ram_we_o,
  output logic [AW-1:0]                     ram_waddr_o,
  output logic [7:0]                        ram_wdata_o
);

  localparam int unsigned FILL_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned BUSY_W = $clog2(albs_pkg::QUEUE_DEPTH + 2);

  logic                         seq_q, seq_d;
  logic                         await_q, await_d;
  logic [FILL_W-1:0]            fill_q, fill_d;
  logic [albs_pkg::TIMER_W-1:0] timer_q, timer_d, timer_inc;
  logic [BUSY_W-1:0]            busy_q, busy_d;
  logic [albs_pkg::STAT_W-1:0]  stat_q [albs_pkg::NUM_STATS];
  logic [albs_pkg::NUM_STATS-1:0] stat_inc;
  logic [albs_pkg::STAT_W-1:0]  byte_add;
  logic                         accept;
  logic                         store_wr;
  logic                         transmit;
  logic                         full;
  logic [albs_pkg::POS_W-1:0]   wpos;
  albs_pkg::cmd_t               cmd;

  assign s_ready_o = !q_full_i && !(busy_q != '0 && !await_q);
  assign accept    = s_valid_i && s_ready_o;
  assign full      = (fill_q >= FILL_W'(MAX_PAYLOAD));
  assign timer_inc = timer_q + albs_pkg::TIMER_W'(1);

  always_comb begin
    seq_d    = seq_q;
    await_d  = await_q;
    fill_d   = fill_q;
    timer_d  = timer_q;
    stat_inc = '0;
    byte_add = '0;
    store_wr = 1'b0;
    transmit = 1'b0;
    cmd      = '0;
    cmd.status = albs_pkg::ST_ACCEPTED;

    unique case (req_type_i)
      albs_pkg::REQ_DATA: begin
        if (await_q) begin
          cmd.status = albs_pkg::ST_BUSY;
        end else if (data_byte_i != albs_pkg::NEWLINE_CHAR) begin
          if (full) begin
            cmd.status = albs_pkg::ST_OVERFLOW;
          end else begin
            store_wr = 1'b1;
            fill_d   = fill_q + FILL_W'(1);
          end
        end else begin
          if (!full) begin
            store_wr = 1'b1;
            fill_d   = fill_q + FILL_W'(1);
          end
          stat_inc[albs_pkg::STAT_ORIG] = 1'b1;
          byte_add = albs_pkg::STAT_W'(fill_d);
          await_d  = 1'b1;
          timer_d  = '0;
          transmit = 1'b1;
        end
      end
      albs_pkg::REQ_EOF: begin
        if (await_q) begin
          cmd.status = albs_pkg::ST_BUSY;
        end else begin
          seq_d        = 1'b0;
          fill_d       = '0;
          cmd.is_frame = 1'b1;
          cmd.status   = albs_pkg::ST_SENT;
          cmd.hdr_seq  = seq_q;
          cmd.len      = '0;
        end
      end
      albs_pkg::REQ_ACK: begin
        if (!await_q) begin
          cmd.status = albs_pkg::ST_STALE;
        end else begin
          stat_inc[albs_pkg::STAT_ACKS] = 1'b1;
          timer_d = '0;
          if (ack_number_i == 16'(seq_q)) begin
            seq_d      = !seq_q;
            await_d    = 1'b0;
            fill_d     = '0;
            cmd.status = albs_pkg::ST_ACK_OK;
          end else begin
            cmd.status = albs_pkg::ST_STALE;
          end
        end
      end
      albs_pkg::REQ_TICK: begin
        if (await_q) begin
          if (timer_inc >= timeout_i) begin
            timer_d  = '0;
            stat_inc[albs_pkg::STAT_TIMEOUTS] = 1'b1;
            transmit = 1'b1;
          end else begin
            timer_d = timer_inc;
          end
        end
      end
      albs_pkg::REQ_STAT: begin
        cmd.status = albs_pkg::ST_STAT;
        if (stat_select_i < 3'(albs_pkg::NUM_STATS)) begin
          cmd.stat_value = stat_q[stat_select_i];
        end
      end
      default: begin
        cmd.status = albs_pkg::ST_ACCEPTED;
      end
    endcase

    if (transmit) begin
      stat_inc[albs_pkg::STAT_TOTAL] = 1'b1;
      if (drop_frame_i) begin
        stat_inc[albs_pkg::STAT_DROPS] = 1'b1;
        cmd.status = albs_pkg::ST_LOST;
      end else begin
        stat_inc[albs_pkg::STAT_SENT] = 1'b1;
        cmd.is_frame = 1'b1;
        cmd.status   = albs_pkg::ST_SENT;
        cmd.hdr_seq  = seq_q;
        cmd.len      = albs_pkg::LEN_W'(fill_d);
      end
    end

    cmd.seq_out = seq_d;
  end

  // Payload byte i sits at frame position i + 4, so each lane RAM holds one byte column.
  assign wpos        = albs_pkg::POS_W'(fill_q) + albs_pkg::POS_W'(albs_pkg::HDR_BYTES);
  assign ram_waddr_o = AW'(wpos >> 3);
  assign ram_wdata_o = data_byte_i;
  assign ram_we_o    = (accept && store_wr) ? (8'd1 << wpos[2:0]) : 8'd0;
  assign push_o      = accept;
  assign cmd_o       = cmd;

  assign busy_d = busy_q + BUSY_W'(accept && cmd.is_frame) - BUSY_W'(frame_done_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= 1'b0;
      await_q <= 1'b0;
      fill_q  <= '0;
      timer_q <= '0;
      busy_q  <= '0;
      for (int i = 0; i < albs_pkg::NUM_STATS; i++) begin
        stat_q[i] <= '0;
      end
    end else begin
      busy_q <= busy_d;
      if (accept) begin
        seq_q   <= seq_d;
        await_q <= await_d;
        fill_q  <= fill_d;
        timer_q <= timer_d;
        for (int i = 0; i < albs_pkg::NUM_STATS; i++) begin
          if (i == albs_pkg::STAT_ORIG_BYTES) begin
            stat_q[i] <= stat_q[i] + byte_add;
          end else begin
            stat_q[i] <= stat_q[i] + albs_pkg::STAT_W'(stat_inc[i]);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/albs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module albs_back #(
  parameter int unsigned MAX_PAYLOAD = 80,
  parameter int unsigned WORDS       = (MAX_PAYLOAD + albs_pkg::HDR_BYTES + 7) / 8,
  parameter int unsigned AW          = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  input  wire albs_pkg::cmd_t     cmd_i,
  output logic                    pop_o,
  output logic [AW-1:0]           ram_raddr_o,
  input  wire logic [63:0]        ram_rdata_i,
  output logic                    frame_done_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output albs_pkg::res_t          res_o
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [AW-1:0]              word_q, word_d;
  albs_pkg::cmd_t             cur_q, cur_d;
  logic                       out_valid_q, out_valid_d;
  albs_pkg::res_t             res_q, res_d;
  logic                       slot_free;
  logic [albs_pkg::POS_W-1:0] total;
  logic [albs_pkg::POS_W-1:0] pos;
  logic [albs_pkg::POS_W-1:0] rem;
  logic                       last;
  logic [3:0]                 cnt;
  logic [31:0]                hdr;
  logic [63:0]                fword;

  assign slot_free = !out_valid_q || m_ready_i;
  assign total = albs_pkg::POS_W'(cur_q.len) + albs_pkg::POS_W'(albs_pkg::HDR_BYTES);
  assign pos   = albs_pkg::POS_W'(word_q) << 3;
  assign rem   = total - pos;
  assign last  = (rem <= albs_pkg::POS_W'(albs_pkg::WORD_BYTES));
  assign cnt   = last ? rem[3:0] : 4'(albs_pkg::WORD_BYTES);
  // The length never exceeds one byte, so its high header byte is zero.
  assign hdr   = {8'h00, 7'd0, cur_q.hdr_seq, 8'h00, cur_q.len};

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      if (4'(b) >= cnt) begin
        fword[8*b +: 8] = 8'h00;
      end else if (word_q == '0 && b < albs_pkg::HDR_BYTES) begin
        fword[8*b +: 8] = hdr[8*b +: 8];
      end else begin
        fword[8*b +: 8] = ram_rdata_i[8*b +: 8];
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    word_d       = word_q;
    cur_d        = cur_q;
    pop_o        = 1'b0;
    frame_done_o = 1'b0;
    out_valid_d  = out_valid_q && !m_ready_i;
    res_d        = res_q;

    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          pop_o = 1'b1;
          if (cmd_i.is_frame) begin
            cur_d   = cmd_i;
            word_d  = '0;
            state_d = B_READ;
          end else begin
            out_valid_d      = 1'b1;
            res_d            = '0;
            res_d.last_word  = 1'b1;
            res_d.seq_bit    = cmd_i.seq_out;
            res_d.status     = cmd_i.status;
            res_d.stat_value = cmd_i.stat_value;
          end
        end
      end
      B_READ: begin
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          res_d.is_frame   = 1'b1;
          res_d.frame_word = fword;
          res_d.word_bytes = cnt;
          res_d.last_word  = last;
          res_d.seq_bit    = cur_q.seq_out;
          res_d.status     = cur_q.status;
          res_d.stat_value = '0;
          if (last) begin
            frame_done_o = 1'b1;
            state_d      = B_IDLE;
          end else begin
            word_d  = word_q + AW'(1);
            state_d = B_READ;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  assign ram_raddr_o = word_q;
  assign m_valid_o   = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/alternating_bit_line_sender.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  request item: kind in tuser, byte, ack, drop, select
// m_*       out        m_tvalid/m_tready  result item: frame flag in tuser, end of frame in tlast
// APB       in         psel/penable       timeout_ticks register at byte address 0
//
// A status result passes through the command queue and the back end's output register; items
// that give status results are taken one per cycle while the two-entry command queue has room.
// A frame of L payload bytes fills ceil((L + 4) / 8) words; the back end takes the command, then
// does a RAM read and an output load for each word.
// Items are held off while a frame is still being emitted and no ACK is awaited.
// Reset clears all control state and counters; the payload RAM needs no clearing pass.
module alternating_bit_line_sender #(
  parameter int unsigned MAX_PAYLOAD = 80
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [31:0]   s_tdata,  // data_byte, ack_number, drop_frame, stat_select, zeros
  input  wire logic [2:0]    s_tuser,  // req_type
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [103:0]       m_tdata,  // frame_word, word_bytes, seq_bit, status, stat_value
  output logic               m_tuser,  // is_frame
  output logic               m_tlast,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned WORDS = (MAX_PAYLOAD + albs_pkg::HDR_BYTES + 7) / 8;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [albs_pkg::TIMER_W-1:0] timeout_q;
  logic                         cfg_wr;
  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_valid;
  albs_pkg::cmd_t               push_cmd;
  albs_pkg::cmd_t               head_cmd;
  logic                         frame_done;
  logic [7:0]                   ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [7:0]                   ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [63:0]                  ram_rdata;
  albs_pkg::res_t               res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == albs_pkg::REG_TIMEOUT) ? {8'h00, timeout_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= albs_pkg::TIMEOUT_RESET;
    end else if (cfg_wr && paddr[2] == albs_pkg::REG_TIMEOUT) begin
      timeout_q <= pwdata[albs_pkg::TIMER_W-1:0];
    end
  end

  albs_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_tvalid),
    .s_ready_o     (s_tready),
    .req_type_i    (s_tuser),
    .data_byte_i   (s_tdata[7:0]),
    .ack_number_i  (s_tdata[23:8]),
    .drop_frame_i  (s_tdata[24]),
    .stat_select_i (s_tdata[27:25]),
    .timeout_i     (timeout_q),
    .q_full_i      (q_full),
    .frame_done_i  (frame_done),
    .push_o        (q_push),
    .cmd_o         (push_cmd),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata)
  );

  albs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  for (genvar l = 0; l < 8; l++) begin : g_lane
    albs_ram #(
      .WIDTH (8),
      .DEPTH (WORDS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[l]),
      .waddr_i (ram_waddr),
      .wdata_i (ram_wdata),
      .raddr_i (ram_raddr),
      .rdata_o (ram_rdata[8*l +: 8])
    );
  end

  albs_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (head_cmd),
    .pop_o        (q_pop),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .frame_done_o (frame_done),
    .m_valid_o    (m_tvalid),
    .m_ready_i    (m_tready),
    .res_o        (res)
  );

  assign m_tdata = {res.stat_value, res.status, res.seq_bit, res.word_bytes, res.frame_word};
  assign m_tuser = res.is_frame;
  assign m_tlast = res.last_word;

  a_frame_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser |-> m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd8
      && (m_tlast || m_tdata[67:64] == 4'd8) && m_tdata[71:69] == albs_pkg::ST_SENT)
    else $error("frame word with bad byte count or status");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[67:0] == 68'd0)
    else $error("status result carries frame data");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// File: tb/alternating_bit_line_sender_tb.sv
`timescale 1ns / 1ps

module alternating_bit_line_sender_tb;

  localparam int unsigned PAYLOAD_MAX = 80;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS = 32;
  localparam logic [2:0] TIMEOUT_ADDR = 3'(4 * int'(albs_pkg::REG_TIMEOUT));
  localparam logic [2:0] REQ_RESERVED = 3'd7;
  localparam logic [2:0] STAT_NONE = 3'd7;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  data_byte;
    logic [15:0] ack_number;
    logic        drop_frame;
    logic [2:0]  stat_select;
  } line_request_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [31:0]   s_tdata = '0;  // data_byte, ack_number, drop_frame, stat_select, zeros
  logic [2:0]    s_tuser = '0;  // req_type
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [103:0]  m_tdata;       // frame_word, word_bytes, seq_bit, status, stat_value
  logic          m_tuser;       // is_frame
  logic          m_tlast;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  alternating_bit_line_sender #(
    .MAX_PAYLOAD(PAYLOAD_MAX)
  ) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  line_request_t   requests_pending[$];
  albs_pkg::res_t  results_due[$];
  line_request_t   on_bus;
  int              requests_queued = 0;
  int              requests_sent = 0;
  int              results_seen = 0;
  int              fail_count = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;

  logic            plan_seq = 1'b0;
  logic            plan_waiting = 1'b0;

  logic [albs_pkg::TIMER_W-1:0] timeout_cfg = albs_pkg::TIMEOUT_RESET;
  logic                         tx_seq = 1'b0;
  logic                         tx_waiting = 1'b0;
  logic [7:0]                   line_buf [PAYLOAD_MAX];
  int unsigned                  line_fill = 0;
  logic [albs_pkg::TIMER_W-1:0] ack_timer = '0;
  logic [albs_pkg::STAT_W-1:0]  link_stats [albs_pkg::NUM_STATS];

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void push_status(logic [2:0] code, logic [albs_pkg::STAT_W-1:0] value);
    albs_pkg::res_t r;
    r = '0;
    r.last_word = 1'b1;
    r.seq_bit = tx_seq;
    r.status = code;
    r.stat_value = value;
    results_due.push_back(r);
  endfunction

  function automatic void push_frame(int unsigned len, logic hdr_seq);
    albs_pkg::res_t r;
    int unsigned    total;
    int unsigned    pos;
    int unsigned    k;
    logic [7:0]     b;
    total = albs_pkg::HDR_BYTES + len;
    pos = 0;
    while (pos < total) begin
      r = '0;
      r.is_frame = 1'b1;
      for (k = 0; k < albs_pkg::WORD_BYTES && pos < total; k++) begin
        case (pos)
          0: b = len[7:0];
          1: b = len[15:8];
          2: b = {7'd0, hdr_seq};
          3: b = 8'd0;
          default: b = line_buf[pos - albs_pkg::HDR_BYTES];
        endcase
        r.frame_word[8*k +: 8] = b;
        pos++;
      end
      r.word_bytes = 4'(k);
      r.last_word = (pos == total);
      r.seq_bit = tx_seq;
      r.status = albs_pkg::ST_SENT;
      results_due.push_back(r);
    end
  endfunction

  function automatic void send_attempt(logic drop);
    link_stats[albs_pkg::STAT_TOTAL]++;
    if (drop) begin
      link_stats[albs_pkg::STAT_DROPS]++;
      push_status(albs_pkg::ST_LOST, '0);
    end else begin
      link_stats[albs_pkg::STAT_SENT]++;
      push_frame(line_fill, tx_seq);
    end
  endfunction

  function automatic void predict_line_sender(line_request_t q);
    logic hdr_seq;
    case (q.req_type)
      albs_pkg::REQ_DATA: begin
        if (tx_waiting) begin
          push_status(albs_pkg::ST_BUSY, '0);
        end else if (q.data_byte != albs_pkg::NEWLINE_CHAR) begin
          if (line_fill >= PAYLOAD_MAX) begin
            push_status(albs_pkg::ST_OVERFLOW, '0);
          end else begin
            line_buf[line_fill] = q.data_byte;
            line_fill++;
            push_status(albs_pkg::ST_ACCEPTED, '0);
          end
        end else begin
          if (line_fill < PAYLOAD_MAX) begin
            line_buf[line_fill] = q.data_byte;
            line_fill++;
          end
          link_stats[albs_pkg::STAT_ORIG]++;
          link_stats[albs_pkg::STAT_ORIG_BYTES] += line_fill;
          tx_waiting = 1'b1;
          ack_timer = '0;
          send_attempt(q.drop_frame);
        end
      end
      albs_pkg::REQ_EOF: begin
        if (tx_waiting) begin
          push_status(albs_pkg::ST_BUSY, '0);
        end else begin
          hdr_seq = tx_seq;
          tx_seq = 1'b0;
          line_fill = 0;
          push_frame(0, hdr_seq);
        end
      end
      albs_pkg::REQ_ACK: begin
        if (!tx_waiting) begin
          push_status(albs_pkg::ST_STALE, '0);
        end else begin
          link_stats[albs_pkg::STAT_ACKS]++;
          ack_timer = '0;
          if (q.ack_number == {15'd0, tx_seq}) begin
            tx_seq = ~tx_seq;
            tx_waiting = 1'b0;
            line_fill = 0;
            push_status(albs_pkg::ST_ACK_OK, '0);
          end else begin
            push_status(albs_pkg::ST_STALE, '0);
          end
        end
      end
      albs_pkg::REQ_TICK: begin
        if (!tx_waiting) begin
          push_status(albs_pkg::ST_ACCEPTED, '0);
        end else begin
          ack_timer = ack_timer + 1'b1;
          if (ack_timer >= timeout_cfg) begin
            ack_timer = '0;
            link_stats[albs_pkg::STAT_TIMEOUTS]++;
            send_attempt(q.drop_frame);
          end else begin
            push_status(albs_pkg::ST_ACCEPTED, '0);
          end
        end
      end
      albs_pkg::REQ_STAT: begin
        push_status(albs_pkg::ST_STAT, (q.stat_select < albs_pkg::NUM_STATS) ?
                    link_stats[q.stat_select] : '0);
      end
      default: begin
        push_status(albs_pkg::ST_ACCEPTED, '0);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        predict_line_sender(on_bus);
        requests_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (requests_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = requests_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= on_bus.req_type;
          s_tdata <= {4'd0, on_bus.stat_select, on_bus.drop_frame, on_bus.ack_number,
                      on_bus.data_byte};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    albs_pkg::res_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("Result with nothing pending: status %0d, frame word %h",
                 m_tdata[71:69], m_tdata[63:0]);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("is_frame", want.is_frame, m_tuser);
          check_field("frame_word", want.frame_word, m_tdata[63:0]);
          check_field("word_bytes", want.word_bytes, m_tdata[67:64]);
          check_field("last_word", want.last_word, m_tlast);
          check_field("seq_bit", want.seq_bit, m_tdata[68]);
          check_field("status", want.status, m_tdata[71:69]);
          check_field("stat_value", want.stat_value, m_tdata[103:72]);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic line_request_t random_request();
    line_request_t r;
    r.req_type = 3'($urandom_range(0, 7));
    r.data_byte = 8'($urandom_range(0, 255));
    r.ack_number = 16'($urandom_range(0, 65535));
    r.drop_frame = 1'($urandom_range(0, 1));
    r.stat_select = 3'($urandom_range(0, 7));
    return r;
  endfunction

  function automatic line_request_t make_request(logic [2:0] kind, logic [7:0] data,
                                                 logic [15:0] ack, logic drop, logic [2:0] sel);
    line_request_t r;
    r.req_type = kind;
    r.data_byte = data;
    r.ack_number = ack;
    r.drop_frame = drop;
    r.stat_select = sel;
    return r;
  endfunction

  // Tracks only the handshake state, so that the generator can answer with a matching ACK.
  function automatic void queue_request(line_request_t r);
    requests_pending.push_back(r);
    requests_queued++;
    case (r.req_type)
      albs_pkg::REQ_DATA: begin
        if (!plan_waiting && r.data_byte == albs_pkg::NEWLINE_CHAR) plan_waiting = 1'b1;
      end
      albs_pkg::REQ_EOF: if (!plan_waiting) plan_seq = 1'b0;
      albs_pkg::REQ_ACK: begin
        if (plan_waiting && r.ack_number == {15'd0, plan_seq}) begin
          plan_seq = ~plan_seq;
          plan_waiting = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_matching_ack();
    line_request_t r;
    r = random_request();
    r.req_type = albs_pkg::REQ_ACK;
    r.ack_number = {15'd0, plan_seq};
    queue_request(r);
  endfunction

  function automatic void queue_exchange(bit force_long);
    line_request_t r;
    int unsigned   line_len;
    if (plan_waiting) queue_matching_ack();
    if (force_long) begin
      line_len = PAYLOAD_MAX + $urandom_range(1, 4);
    end else if ($urandom_range(0, 11) == 0) begin
      line_len = $urandom_range(PAYLOAD_MAX - 3, PAYLOAD_MAX + 3);
    end else begin
      line_len = $urandom_range(0, 14);
    end
    repeat (line_len) begin
      if ($urandom_range(0, 15) == 0) begin
        r = random_request();
        r.req_type = $urandom_range(0, 1) ? albs_pkg::REQ_TICK : albs_pkg::REQ_STAT;
        queue_request(r);
      end
      r = random_request();
      r.req_type = albs_pkg::REQ_DATA;
      if (r.data_byte == albs_pkg::NEWLINE_CHAR) r.data_byte = r.data_byte ^ 8'h01;
      queue_request(r);
    end
    r = random_request();
    r.req_type = albs_pkg::REQ_DATA;
    r.data_byte = albs_pkg::NEWLINE_CHAR;
    r.drop_frame = ($urandom_range(0, 3) == 0);
    queue_request(r);
    repeat ($urandom_range(0, 8)) begin
      r = random_request();
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          r.req_type = albs_pkg::REQ_TICK;
          r.drop_frame = ($urandom_range(0, 2) == 0);
        end
        3: begin
          r.req_type = albs_pkg::REQ_ACK;
          if (r.ack_number == {15'd0, plan_seq}) r.ack_number = r.ack_number ^ 16'h0001;
        end
        4: r.req_type = $urandom_range(0, 1) ? albs_pkg::REQ_DATA : albs_pkg::REQ_EOF;
        default: r.req_type = albs_pkg::REQ_STAT;
      endcase
      queue_request(r);
    end
    queue_matching_ack();
    if ($urandom_range(0, 5) == 0) begin
      r = random_request();
      r.req_type = albs_pkg::REQ_EOF;
      queue_request(r);
    end
  endfunction

  task automatic write_timeout(input logic [albs_pkg::TIMER_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMEOUT_ADDR;
    pwdata <= {8'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    timeout_cfg = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("timeout_ticks readback", value, prdata[albs_pkg::TIMER_W-1:0]);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sampled at the falling edge, where the driver's and monitor's updates have settled.
  task automatic drain_and_settle();
    @(negedge clk_i);
    while (requests_pending.size() != 0 || s_tvalid || results_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [albs_pkg::TIMER_W-1:0] phase_timeouts [7];
    int                           phase_goal;
    int                           k;
    phase_timeouts = '{24'd1, 24'd0, 24'd3, 24'hFFFFFF, 24'd2, 24'd5, 24'd1};
    foreach (link_stats[i]) link_stats[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A two-tick timeout lets the directed part reach both kinds of retransmission.
    write_timeout(24'd2);
    queue_request(make_request(albs_pkg::REQ_STAT, 8'h00, 16'h0000, 1'b0, STAT_NONE));
    queue_request(make_request(REQ_RESERVED, 8'hFF, 16'hFFFF, 1'b1, STAT_NONE));
    queue_request(make_request(albs_pkg::REQ_ACK, 8'h00, 16'h0000, 1'b0, 3'd0));
    queue_request(make_request(albs_pkg::REQ_TICK, 8'h00, 16'h0000, 1'b1, 3'd0));
    queue_request(make_request(albs_pkg::REQ_DATA, 8'h00, 16'h0000, 1'b0, 3'd0));
    queue_request(make_request(albs_pkg::REQ_DATA, 8'hFF, 16'hFFFF, 1'b1, STAT_NONE));
    queue_request(make_request(albs_pkg::REQ_DATA, 8'h41, 16'h0000, 1'b0, 3'd0));
    queue_request(make_request(albs_pkg::REQ_DATA, albs_pkg::NEWLINE_CHAR, 16'h0000, 1'b0,
                               3'd0));
    queue_request(make_request(albs_pkg::REQ_DATA, 8'h55, 16'h0000, 1'b0, 3'd0));
    queue_request(make_request(albs_pkg::REQ_EOF, 8'h00, 16'h0000, 1'b0, 3'd0));
    queue_request(make_request(albs_pkg::REQ_ACK, 8'h00, 16'hFFFF, 1'b0, 3'd0));
    queue_request(make_request(albs_pkg::REQ_TICK, 8'h00, 16'h0000, 1'b1, 3'd0));
    queue_request(make_request(albs_pkg::REQ_TICK, 8'h00, 16'h0000, 1'b1, 3'd0));
    queue_request(make_request(albs_pkg::REQ_TICK, 8'h00, 16'h0000, 1'b0, 3'd0));
    queue_request(make_request(albs_pkg::REQ_TICK, 8'h00, 16'h0000, 1'b0, 3'd0));
    queue_request(make_request(albs_pkg::REQ_ACK, 8'h00, 16'h0001, 1'b0, 3'd0));
    queue_request(make_request(albs_pkg::REQ_ACK, 8'h00, 16'h0000, 1'b0, 3'd0));
    queue_request(make_request(albs_pkg::REQ_DATA, 8'h78, 16'h0000, 1'b0, 3'd0));
    queue_request(make_request(albs_pkg::REQ_EOF, 8'h00, 16'h0000, 1'b0, 3'd0));
    for (k = 0; k < albs_pkg::NUM_STATS; k++)
      queue_request(make_request(albs_pkg::REQ_STAT, 8'h00, 16'h0000, 1'b0, 3'(k)));
    drain_and_settle();

    for (int phase = 0; phase < 7; phase++) begin
      write_timeout(phase_timeouts[phase]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      phase_goal = requests_queued + PHASE_ITEMS;
      if (phase == 1 || phase == 4) queue_exchange(1'b1);
      while (requests_queued < phase_goal) begin
        if ($urandom_range(0, 3) != 0) begin
          queue_exchange(1'b0);
        end else begin
          repeat ($urandom_range(1, 3)) queue_request(random_request());
        end
      end
      drain_and_settle();
    end

    $display("Covered %0d requests and %0d results over eight timeout settings %s",
             requests_sent, results_seen, "and four idling modes.");
    $display("Lines sent: %0d, timeouts: %0d, lost transmissions: %0d.",
             link_stats[albs_pkg::STAT_ORIG], link_stats[albs_pkg::STAT_TIMEOUTS],
             link_stats[albs_pkg::STAT_DROPS]);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: alternating_bit_line_sender.f
rtl/core/albs_pkg.sv
rtl/core/albs_ram.sv
rtl/core/albs_queue.sv
rtl/core/albs_front.sv
rtl/core/albs_back.sv
rtl/core/alternating_bit_line_sender.sv
tb/alternating_bit_line_sender_tb.sv
